@@ rtl/core/uvs_pkg.sv @@
// ----------------------------------------------------------------------------
// UV sphere vertex package
// Shared types, constants and fixed-point helpers for the UV sphere tile
// vertex generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

  // Field widths
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned POS_W    = 15;
  localparam int unsigned NORM_W   = 16;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BAND_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEDGE_COUNT = 1'd1;

  localparam logic [CFG_W-1:0] BAND_COUNT_RST  = 8'd16;
  localparam logic [CFG_W-1:0] WEDGE_COUNT_RST = 8'd16;

  // Vertex sequencing: six vertices per tile
  localparam logic [2:0] VTX_FIRST = 3'd0;
  localparam logic [2:0] VTX_LAST  = 3'd5;

  // Q30 working format
  localparam int unsigned QB = 30;
  localparam logic signed [31:0] C9 = 32'sd172272;
  localparam logic signed [31:0] C7 = -32'sd5026995;
  localparam logic signed [31:0] C5 = 32'sd85569306;
  localparam logic signed [31:0] C3 = -32'sd693598668;
  localparam logic signed [31:0] C1 = 32'sd1686625909;  // 1.0 - C3 - C5 - C7 - C9

  // Sideband that travels with each vertex
  typedef struct packed {
    logic err;
    logic last;
  } vtx_meta_t;

  // Q30 product, rounded toward minus infinity
  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[QB +: 32];
  endfunction

  // Corner of vertex k: bit 1 bottom row, bit 0 right column (BL TR TL BR TR BL)
  function automatic logic [1:0] corner_of(input logic [2:0] k);
    logic [1:0] c;
    unique case (k)
      3'd0:    c = 2'd2;
      3'd1:    c = 2'd1;
      3'd2:    c = 2'd0;
      3'd3:    c = 2'd3;
      3'd4:    c = 2'd1;
      3'd5:    c = 2'd2;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/uvs_if.sv @@
// ----------------------------------------------------------------------------
// UV sphere channel interfaces
// Valid/ready channels for tile requests and vertex results.
// ----------------------------------------------------------------------------
interface uvs_tile_if;
  import uvs_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] wedge_index;
  logic [IDX_W-1:0] band_index;

  modport source (output valid, output wedge_index, output band_index, input ready);
  modport sink   (input valid, input wedge_index, input band_index, output ready);
endinterface

interface uvs_vtx_if;
  import uvs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic signed [NORM_W-1:0] norm_x;
  logic signed [NORM_W-1:0] norm_y;
  logic signed [NORM_W-1:0] norm_z;
  logic                     index_error;
  logic                     last_vertex;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output norm_x, output norm_y, output norm_z,
                  output index_error, output last_vertex, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  input norm_x, input norm_y, input norm_z,
                  input index_error, input last_vertex, output ready);
endinterface

@@ rtl/core/uv_sphere_tile_vertex_generator.sv @@
// ----------------------------------------------------------------------------
// UV sphere tile vertex generator
// Turns one tile request into the six vertices of its two triangles.
// ----------------------------------------------------------------------------
// Pipeline: tile sequencer, issue registers, divider stages, sine stages, normal
//   register and output register, in that order.
// Throughput: one vertex per cycle while the output is not stalled, set by the single
//   vertex output channel; the pipeline stalls as a whole on back-pressure.
// Reset: clears all valid bits and the tile sequencer; counts return to 16.
module uv_sphere_tile_vertex_generator #(
  parameter int unsigned ANGLE_BITS      = 16,
  parameter int unsigned COORD_FRAC_BITS = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [uvs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [uvs_pkg::CFG_W-1:0]     cfg_data_i,
  uvs_tile_if.sink                      tile_i,
  uvs_vtx_if.source                     vtx_o
);
  import uvs_pkg::*;

  localparam int unsigned Q_W    = ANGLE_BITS + 1;
  localparam int unsigned NUM_W  = ANGLE_BITS + 10;
  localparam int unsigned DEN_W  = 9;
  localparam int unsigned DIV_LAT = (Q_W + 3) / 4;
  localparam int unsigned LAST   = DIV_LAT + 8;   // index of the product stage
  localparam int unsigned NRM_SH = QB - COORD_FRAC_BITS;
  localparam int unsigned POS_SH = QB + 1 - COORD_FRAC_BITS;
  localparam logic signed [32:0] NRM_HALF = 33'sd1 <<< (NRM_SH - 1);
  localparam logic signed [32:0] POS_HALF = 33'sd1 <<< (POS_SH - 1);
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  // Configuration registers
  logic [CFG_W-1:0] band_cnt_q, wedge_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_cnt_q  <= BAND_COUNT_RST;
      wedge_cnt_q <= WEDGE_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BAND_COUNT:  band_cnt_q  <= cfg_data_i;
        REG_WEDGE_COUNT: wedge_cnt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Global advance: output slot free or being taken
  logic out_vld_q;
  logic adv;
  assign adv = !out_vld_q || vtx_o.ready;

  // Tile sequencer: holds one tile, issues one vertex per advance
  logic             tile_vld_q;
  logic [IDX_W-1:0] w_q, b_q;
  logic [2:0]       k_q;
  logic             tile_rdy;

  assign tile_rdy     = !tile_vld_q || (k_q == VTX_LAST && adv);
  assign tile_i.ready = tile_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_vld_q <= 1'b0;
      k_q        <= VTX_FIRST;
    end else if (tile_i.valid && tile_rdy) begin
      tile_vld_q <= 1'b1;
      k_q        <= VTX_FIRST;
    end else if (adv && tile_vld_q) begin
      if (k_q == VTX_LAST) begin
        tile_vld_q <= 1'b0;
      end else begin
        k_q <= k_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tile_i.valid && tile_rdy) begin
      w_q <= tile_i.wedge_index;
      b_q <= tile_i.band_index;
    end
  end

  // Issue stage: dividends for the corner's polar and azimuth angles
  logic [1:0]       corner;
  logic [8:0]       m_phi;
  logic [9:0]       m_th;
  logic [NUM_W-1:0] num_phi_d, num_th_d, num_phi_q, num_th_q;
  logic [DEN_W-1:0] den_phi_q, den_th_q;
  vtx_meta_t        meta_d;

  always_comb begin
    corner        = corner_of(k_q);
    m_phi         = {1'b0, b_q} + 9'(corner[1]);
    m_th          = {({1'b0, w_q} + 9'(corner[0])), 1'b0};
    num_phi_d     = (NUM_W'(m_phi) << ANGLE_BITS) + NUM_W'(band_cnt_q);
    num_th_d      = (NUM_W'(m_th) << ANGLE_BITS) + NUM_W'(wedge_cnt_q);
    meta_d.err    = (w_q >= wedge_cnt_q) || (b_q >= band_cnt_q);
    meta_d.last   = (k_q == VTX_LAST);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_phi_q <= num_phi_d;
      num_th_q  <= num_th_d;
      den_phi_q <= {band_cnt_q, 1'b0};
      den_th_q  <= {wedge_cnt_q, 1'b0};
    end
  end

  // Valid bits and sideband travel alongside the datapath
  logic      vld_q  [LAST+1];
  vtx_meta_t meta_q [LAST+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= LAST; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_q[0] <= tile_vld_q;
      for (int i = 1; i <= LAST; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      meta_q[0] <= meta_d;
      for (int i = 1; i <= LAST; i++) begin
        meta_q[i] <= meta_q[i-1];
      end
    end
  end

  // Angle division
  logic [Q_W-1:0] phi_quo, th_quo;

  uvs_div_pipe #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W)) u_div_phi (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (num_phi_q),
    .den_i (den_phi_q),
    .quo_o (phi_quo)
  );

  uvs_div_pipe #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W)) u_div_th (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (num_th_q),
    .den_i (den_th_q),
    .quo_o (th_quo)
  );

  // Four sine lanes: sin/cos of polar angle and azimuth
  logic [ANGLE_BITS-1:0] phi, th;
  logic signed [31:0]    sp, cp, st, ct;

  assign phi = phi_quo[ANGLE_BITS-1:0];
  assign th  = th_quo[ANGLE_BITS-1:0];

  uvs_sin_pipe #(.ANGLE_BITS(ANGLE_BITS)) u_sin_p (
    .clk_i(clk_i), .en_i(adv), .angle_i(phi), .sin_o(sp));
  uvs_sin_pipe #(.ANGLE_BITS(ANGLE_BITS)) u_cos_p (
    .clk_i(clk_i), .en_i(adv), .angle_i(phi + QUARTER), .sin_o(cp));
  uvs_sin_pipe #(.ANGLE_BITS(ANGLE_BITS)) u_sin_t (
    .clk_i(clk_i), .en_i(adv), .angle_i(th), .sin_o(st));
  uvs_sin_pipe #(.ANGLE_BITS(ANGLE_BITS)) u_cos_t (
    .clk_i(clk_i), .en_i(adv), .angle_i(th + QUARTER), .sin_o(ct));

  // Normal components in Q30
  logic signed [31:0] nx_q, ny_q, nz_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nx_q <= mulq(sp, st);
      ny_q <= cp;
      nz_q <= mulq(sp, ct);
    end
  end

  // Round to output format
  logic signed [32:0] nx_r, ny_r, nz_r, px_r, py_r, pz_r;

  always_comb begin
    nx_r = (33'(nx_q) + NRM_HALF) >>> NRM_SH;
    ny_r = (33'(ny_q) + NRM_HALF) >>> NRM_SH;
    nz_r = (33'(nz_q) + NRM_HALF) >>> NRM_SH;
    px_r = (33'(nx_q) + POS_HALF) >>> POS_SH;
    py_r = (33'(ny_q) + POS_HALF) >>> POS_SH;
    pz_r = (33'(nz_q) + POS_HALF) >>> POS_SH;
  end

  // Output register
  logic signed [POS_W-1:0]  pos_x_q, pos_y_q, pos_z_q;
  logic signed [NORM_W-1:0] norm_x_q, norm_y_q, norm_z_q;
  logic                     err_q, last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      err_q  <= meta_q[LAST].err;
      last_q <= meta_q[LAST].last;
      if (meta_q[LAST].err) begin
        pos_x_q  <= '0;
        pos_y_q  <= '0;
        pos_z_q  <= '0;
        norm_x_q <= '0;
        norm_y_q <= '0;
        norm_z_q <= '0;
      end else begin
        pos_x_q  <= px_r[POS_W-1:0];
        pos_y_q  <= py_r[POS_W-1:0];
        pos_z_q  <= pz_r[POS_W-1:0];
        norm_x_q <= nx_r[NORM_W-1:0];
        norm_y_q <= ny_r[NORM_W-1:0];
        norm_z_q <= nz_r[NORM_W-1:0];
      end
    end
  end

  assign vtx_o.valid       = out_vld_q;
  assign vtx_o.pos_x       = pos_x_q;
  assign vtx_o.pos_y       = pos_y_q;
  assign vtx_o.pos_z       = pos_z_q;
  assign vtx_o.norm_x      = norm_x_q;
  assign vtx_o.norm_y      = norm_y_q;
  assign vtx_o.norm_z      = norm_z_q;
  assign vtx_o.index_error = err_q;
  assign vtx_o.last_vertex = last_q;

endmodule

@@ rtl/core/uvs_div_pipe.sv @@
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned quotient, up to four quotient bits resolved per register stage.
// ----------------------------------------------------------------------------
module uvs_div_pipe #(
  parameter int unsigned NUM_W = 26,
  parameter int unsigned DEN_W = 9,
  parameter int unsigned Q_W   = 17
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o
);

  localparam int unsigned STEP = 4;
  localparam int unsigned NSTG = (Q_W + STEP - 1) / STEP;
  localparam int unsigned R_W  = DEN_W + 1;

  logic [R_W-1:0]   rem_q [NSTG];
  logic [Q_W-1:0]   lo_q  [NSTG];
  logic [Q_W-1:0]   quo_q [NSTG];
  logic [DEN_W-1:0] den_q [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic [R_W-1:0]   r_in;
    logic [Q_W-1:0]   lo_in;
    logic [Q_W-1:0]   q_in;
    logic [DEN_W-1:0] d_in;
    logic [R_W-1:0]   r_d;
    logic [Q_W-1:0]   lo_d;
    logic [Q_W-1:0]   q_d;

    if (s == 0) begin : g_head
      assign r_in  = R_W'(num_i >> Q_W);
      assign lo_in = num_i[Q_W-1:0];
      assign q_in  = '0;
      assign d_in  = den_i;
    end else begin : g_body
      assign r_in  = rem_q[s-1];
      assign lo_in = lo_q[s-1];
      assign q_in  = quo_q[s-1];
      assign d_in  = den_q[s-1];
    end

    // shift in one dividend bit, subtract when it fits
    always_comb begin
      r_d  = r_in;
      lo_d = lo_in;
      q_d  = q_in;
      for (int j = 0; j < STEP; j++) begin
        if (s * STEP + j < Q_W) begin
          r_d  = {r_d[R_W-2:0], lo_d[Q_W-1]};
          lo_d = lo_d << 1;
          if (r_d >= R_W'(d_in)) begin
            r_d = r_d - R_W'(d_in);
            q_d = {q_d[Q_W-2:0], 1'b1};
          end else begin
            q_d = {q_d[Q_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= r_d;
        lo_q[s]  <= lo_d;
        quo_q[s] <= q_d;
        den_q[s] <= d_in;
      end
    end
  end

  assign quo_o = quo_q[NSTG-1];

endmodule

@@ rtl/core/uvs_sin_pipe.sv @@
// ----------------------------------------------------------------------------
// Pipelined sine of a turn fraction
// Quadrant fold, then odd polynomial by Horner's rule, at most one multiply per stage.
// ----------------------------------------------------------------------------
module uvs_sin_pipe #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [ANGLE_BITS-1:0] angle_i,
  output logic signed [31:0]    sin_o
);
  import uvs_pkg::*;

  localparam int unsigned XSH = QB - (ANGLE_BITS - 2);
  localparam logic [ANGLE_BITS-2:0] QUARTER = (ANGLE_BITS-1)'(1) << (ANGLE_BITS - 2);

  logic [1:0]            quad;
  logic [ANGLE_BITS-2:0] r_f;
  logic signed [31:0]    x_f;

  logic signed [31:0] x_q   [6];
  logic               neg_q [6];
  logic signed [31:0] x2_q  [4];
  logic signed [31:0] t_q   [4];
  logic signed [31:0] sin_q;
  logic signed [31:0] prod;

  // fold into the first quadrant, x in [0,1] as Q30
  always_comb begin
    quad = angle_i[ANGLE_BITS-1 -: 2];
    r_f  = {1'b0, angle_i[ANGLE_BITS-3:0]};
    if (quad[0]) begin
      r_f = QUARTER - r_f;
    end
    x_f = 32'(r_f) << XSH;
  end

  assign prod = mulq(t_q[3], x_q[5]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= x_f;
      neg_q[0] <= quad[1];
      for (int i = 1; i < 6; i++) begin
        x_q[i]   <= x_q[i-1];
        neg_q[i] <= neg_q[i-1];
      end
      x2_q[0] <= mulq(x_q[0], x_q[0]);
      for (int i = 1; i < 4; i++) begin
        x2_q[i] <= x2_q[i-1];
      end
      t_q[0] <= C7 + mulq(C9, x2_q[0]);
      t_q[1] <= C5 + mulq(t_q[0], x2_q[1]);
      t_q[2] <= C3 + mulq(t_q[1], x2_q[2]);
      t_q[3] <= C1 + mulq(t_q[2], x2_q[3]);
      sin_q  <= neg_q[5] ? -prod : prod;
    end
  end

  assign sin_o = sin_q;

endmodule

@@ rtl/core/uvs_checker.sv @@
// ----------------------------------------------------------------------------
// UV sphere port checker
// Port-level properties of the tile vertex generator, bound to the top level.
// ----------------------------------------------------------------------------
module uvs_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 tile_valid_i,
  input logic                                 tile_ready_i,
  input logic                                 vtx_valid_i,
  input logic                                 vtx_ready_i,
  input logic signed [uvs_pkg::POS_W-1:0]     pos_x_i,
  input logic signed [uvs_pkg::POS_W-1:0]     pos_y_i,
  input logic signed [uvs_pkg::POS_W-1:0]     pos_z_i,
  input logic signed [uvs_pkg::NORM_W-1:0]    norm_x_i,
  input logic signed [uvs_pkg::NORM_W-1:0]    norm_y_i,
  input logic signed [uvs_pkg::NORM_W-1:0]    norm_z_i,
  input logic                                 index_error_i,
  input logic                                 last_vertex_i
);
  import uvs_pkg::*;

  logic       tile_xfer, vtx_xfer;
  logic [2:0] vcnt_q;
  logic [8:0] pend_q;

  assign tile_xfer = tile_valid_i && tile_ready_i;
  assign vtx_xfer  = vtx_valid_i && vtx_ready_i;

  // vertex position within its tile, and vertices owed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q <= VTX_FIRST;
      pend_q <= '0;
    end else begin
      if (vtx_xfer) begin
        vcnt_q <= (vcnt_q == VTX_LAST) ? VTX_FIRST : vcnt_q + 3'd1;
      end
      pend_q <= pend_q + (tile_xfer ? 9'd6 : 9'd0) - (vtx_xfer ? 9'd1 : 9'd0);
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vtx_valid_i && !vtx_ready_i |=> vtx_valid_i && $stable(pos_x_i) && $stable(norm_y_i)
      && $stable(last_vertex_i))
    else $error("vertex changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vtx_valid_i && index_error_i |-> pos_x_i == 0 && pos_y_i == 0 && pos_z_i == 0
      && norm_x_i == 0 && norm_y_i == 0 && norm_z_i == 0)
    else $error("error vertex carries nonzero data");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vtx_valid_i |-> last_vertex_i == (vcnt_q == VTX_LAST))
    else $error("last_vertex not on the sixth vertex");

  a_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vtx_valid_i |-> pend_q != 9'd0)
    else $error("vertex without a pending tile");

endmodule

bind uv_sphere_tile_vertex_generator uvs_checker u_uvs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .tile_valid_i  (tile_i.valid),
  .tile_ready_i  (tile_i.ready),
  .vtx_valid_i   (vtx_o.valid),
  .vtx_ready_i   (vtx_o.ready),
  .pos_x_i       (vtx_o.pos_x),
  .pos_y_i       (vtx_o.pos_y),
  .pos_z_i       (vtx_o.pos_z),
  .norm_x_i      (vtx_o.norm_x),
  .norm_y_i      (vtx_o.norm_y),
  .norm_z_i      (vtx_o.norm_z),
  .index_error_i (vtx_o.index_error),
  .last_vertex_i (vtx_o.last_vertex)
);
